[hw/rtl/pfat_pkg.sv]
`default_nettype none
package pfat_pkg;

  localparam int MAX_FRAMES = 256;
  localparam int MAX_SLOTS  = 8;
  localparam int MAX_PAGES  = 64;

  localparam int FRAME_W = $clog2(MAX_FRAMES);
  localparam int CNT_W   = $clog2(MAX_FRAMES + 1);
  localparam int SLOT_W  = $clog2(MAX_SLOTS);
  localparam int PIDX_W  = $clog2(MAX_PAGES);
  localparam int LEN_W   = $clog2(MAX_PAGES + 1);
  localparam int TBL_DEPTH = MAX_SLOTS * MAX_PAGES;

  localparam int OP_W    = 2;
  localparam int STAT_W  = 3;
  localparam int REQ_W   = 22;
  localparam int ADDR_W  = 22;
  localparam int OFF_W   = 16;
  localparam int PAGES_W = 7;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 1;

  localparam logic [CFG_IDX_W-1:0] REG_PAGE_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_PHYS_BITS = 1'b1;

  localparam logic [CFG_W-1:0] PAGE_BITS_RST = 5'd8;
  localparam logic [CFG_W-1:0] PHYS_BITS_RST = 5'd16;

  typedef enum logic [OP_W-1:0] {
    OP_SETUP     = 2'd0,
    OP_CREATE    = 2'd1,
    OP_TERMINATE = 2'd2,
    OP_ACCESS    = 2'd3
  } pfat_op_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK       = 3'd0,
    STAT_FEW      = 3'd1,
    STAT_NO_PAGE  = 3'd2,
    STAT_BUSY     = 3'd3,
    STAT_EMPTY    = 3'd4,
    STAT_TOO_MANY = 3'd5
  } pfat_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_POP_RD,
    S_POP_WR,
    S_PUSH_RD,
    S_PUSH_WR,
    S_DONE
  } pfat_state_e;

  typedef struct packed {
    logic         latch;
    logic         setup;
    logic         claim;
    logic         free_slot;
    logic         pop_rd;
    logic         pop_wr;
    logic         push_rd;
    logic         push_wr;
    logic         xlate_rd;
    logic         stat_set;
    pfat_status_e stat;
    logic         emit;
  } pfat_cmd_t;

  typedef struct packed {
    pfat_op_e op;
    logic     in_use;
    logic     too_many;
    logic     too_few;
    logic     pages_zero;
    logic     len_zero;
    logic     page_oob;
    logic     last;
  } pfat_sts_t;

endpackage
`default_nettype wire

[hw/rtl/pfat_ram.sv]
`default_nettype none
module pfat_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [W-1:0]             wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [W-1:0]             rdata_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

[hw/rtl/pfat_ctrl.sv]
`default_nettype none
module pfat_ctrl (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire pfat_pkg::pfat_sts_t sts_i,
  output pfat_pkg::pfat_cmd_t      cmd_o,
  output logic                     busy_o
);

  pfat_pkg::pfat_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfat_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfat_pkg::S_IDLE: begin
        if (start_i) state_d = pfat_pkg::S_DECODE;
      end
      pfat_pkg::S_DECODE: begin
        state_d = pfat_pkg::S_DONE;
        unique case (sts_i.op)
          pfat_pkg::OP_CREATE: begin
            if (!sts_i.in_use && !sts_i.too_many && !sts_i.too_few && !sts_i.pages_zero)
              state_d = pfat_pkg::S_POP_RD;
          end
          pfat_pkg::OP_TERMINATE: begin
            if (sts_i.in_use && !sts_i.len_zero) state_d = pfat_pkg::S_PUSH_RD;
          end
          default: state_d = pfat_pkg::S_DONE;
        endcase
      end
      pfat_pkg::S_POP_RD:  state_d = pfat_pkg::S_POP_WR;
      pfat_pkg::S_POP_WR:  state_d = sts_i.last ? pfat_pkg::S_DONE : pfat_pkg::S_POP_RD;
      pfat_pkg::S_PUSH_RD: state_d = pfat_pkg::S_PUSH_WR;
      pfat_pkg::S_PUSH_WR: state_d = sts_i.last ? pfat_pkg::S_DONE : pfat_pkg::S_PUSH_RD;
      pfat_pkg::S_DONE:    state_d = pfat_pkg::S_IDLE;
      default:             state_d = pfat_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      pfat_pkg::S_IDLE: begin
        cmd_o.latch = start_i;
      end
      pfat_pkg::S_DECODE: begin
        cmd_o.stat_set = 1'b1;
        cmd_o.stat     = pfat_pkg::STAT_OK;
        unique case (sts_i.op)
          pfat_pkg::OP_SETUP: begin
            cmd_o.setup = 1'b1;
          end
          pfat_pkg::OP_CREATE: begin
            priority if (sts_i.in_use) begin
              cmd_o.stat = pfat_pkg::STAT_BUSY;
            end else if (sts_i.too_many) begin
              cmd_o.stat = pfat_pkg::STAT_TOO_MANY;
            end else if (sts_i.too_few) begin
              cmd_o.stat = pfat_pkg::STAT_FEW;
            end else begin
              cmd_o.claim = 1'b1;
            end
          end
          pfat_pkg::OP_TERMINATE: begin
            if (!sts_i.in_use) begin
              cmd_o.stat = pfat_pkg::STAT_EMPTY;
            end else if (sts_i.len_zero) begin
              cmd_o.free_slot = 1'b1;
            end
          end
          pfat_pkg::OP_ACCESS: begin
            priority if (!sts_i.in_use) begin
              cmd_o.stat = pfat_pkg::STAT_EMPTY;
            end else if (sts_i.page_oob) begin
              cmd_o.stat = pfat_pkg::STAT_NO_PAGE;
            end else begin
              cmd_o.xlate_rd = 1'b1;
            end
          end
          default: cmd_o.stat = pfat_pkg::STAT_OK;
        endcase
      end
      pfat_pkg::S_POP_RD:  cmd_o.pop_rd = 1'b1;
      pfat_pkg::S_POP_WR:  cmd_o.pop_wr = 1'b1;
      pfat_pkg::S_PUSH_RD: cmd_o.push_rd = 1'b1;
      pfat_pkg::S_PUSH_WR: begin
        cmd_o.push_wr   = 1'b1;
        cmd_o.free_slot = sts_i.last;
      end
      pfat_pkg::S_DONE:    cmd_o.emit = 1'b1;
      default:             cmd_o = '0;
    endcase
  end

  assign busy_o = (state_q != pfat_pkg::S_IDLE);

endmodule
`default_nettype wire

[hw/rtl/pfat_dp.sv]
`default_nettype none
module pfat_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [pfat_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire logic [pfat_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire logic [pfat_pkg::OP_W-1:0]         op_i,
  input  wire logic [pfat_pkg::SLOT_W-1:0]       process_slot_i,
  input  wire logic [pfat_pkg::REQ_W-1:0]        mem_req_i,
  input  wire logic [pfat_pkg::ADDR_W-1:0]       address_i,
  input  wire pfat_pkg::pfat_cmd_t               cmd_i,
  output pfat_pkg::pfat_sts_t                    sts_o,
  output logic                                   done_o,
  output logic [pfat_pkg::STAT_W-1:0]            status_o,
  output logic [pfat_pkg::FRAME_W-1:0]           frame_o,
  output logic [pfat_pkg::OFF_W-1:0]             offset_o,
  output logic [pfat_pkg::PAGES_W-1:0]           pages_allocated_o,
  output logic [pfat_pkg::OFF_W-1:0]             fragmentation_o,
  output logic [pfat_pkg::CNT_W-1:0]             free_frames_o
);

  localparam int FW  = pfat_pkg::FRAME_W;
  localparam int CW  = pfat_pkg::CNT_W;
  localparam int LW  = pfat_pkg::LEN_W;
  localparam int PW  = pfat_pkg::PIDX_W;
  localparam int SW  = pfat_pkg::SLOT_W;
  localparam int RW  = pfat_pkg::REQ_W;
  localparam int AW  = pfat_pkg::ADDR_W;
  localparam int OW  = pfat_pkg::OFF_W;
  localparam int TAW = SW + PW;

  function automatic logic [CW-1:0] frame_total(input logic [pfat_pkg::CFG_W-1:0] pb,
                                                input logic [pfat_pkg::CFG_W-1:0] phys);
    logic [pfat_pkg::CFG_W-1:0] d;
    logic [CW-1:0]              n;
    d = phys - pb;
    if (phys < pb) begin
      n = '0;
    end else if (32'(d) >= FW) begin
      n = CW'(pfat_pkg::MAX_FRAMES);
    end else begin
      n = CW'(1) << d;
    end
    return n;
  endfunction

  logic [pfat_pkg::CFG_W-1:0] page_bits_q, phys_bits_q;
  logic [CW-1:0]              free_count_q;
  logic [pfat_pkg::MAX_FRAMES-1:0] valid_q;
  logic [LW-1:0]              len_q [pfat_pkg::MAX_SLOTS];
  logic [pfat_pkg::MAX_SLOTS-1:0] use_q;
  logic [PW-1:0]              idx_q;
  logic                       done_q;

  pfat_pkg::pfat_op_e         op_q;
  pfat_pkg::pfat_status_e     stat_q;
  logic [SW-1:0]              slot_q;
  logic [RW-1:0]              req_q;
  logic [AW-1:0]              addr_q;
  logic [FW-1:0]              sel_addr_q;
  logic                       sel_valid_q;

  logic [pfat_pkg::STAT_W-1:0]  status_q;
  logic [FW-1:0]                frame_q;
  logic [OW-1:0]                offset_q;
  logic [pfat_pkg::PAGES_W-1:0] pages_q;
  logic [OW-1:0]                frag_q;
  logic [CW-1:0]                free_frames_q;

  logic [RW-1:0]  req_mask;
  logic [RW:0]    pages;
  logic [OW-1:0]  m16;
  logic [OW-1:0]  frag;
  logic [OW-1:0]  offset;
  logic [AW-1:0]  page;
  logic [CW-1:0]  cnt_dec;
  logic           stack_full;
  logic [FW-1:0]  stk_rdata;
  logic [FW-1:0]  tbl_rdata;
  logic [FW-1:0]  pop_frame;
  logic [TAW-1:0] tbl_raddr;
  logic [LW-1:0]  cur_len;

  assign req_mask = ~({RW{1'b1}} << page_bits_q);
  assign pages    = {1'b0, req_q >> page_bits_q} + (RW+1)'(|(req_q & req_mask));
  assign m16      = ~({OW{1'b1}} << page_bits_q);
  assign frag     = (OW'(0) - (req_q[OW-1:0] & m16)) & m16;
  assign offset   = addr_q[OW-1:0] & m16;
  assign page     = addr_q >> page_bits_q;
  assign cnt_dec  = free_count_q - CW'(1);
  assign stack_full = (free_count_q >= CW'(pfat_pkg::MAX_FRAMES));
  assign cur_len  = len_q[slot_q];
  assign pop_frame = sel_valid_q ? stk_rdata : sel_addr_q;
  assign tbl_raddr = cmd_i.xlate_rd ? {slot_q, page[PW-1:0]} : {slot_q, idx_q};

  assign sts_o.op         = op_q;
  assign sts_o.in_use     = use_q[slot_q];
  assign sts_o.too_many   = (pages > (RW+1)'(pfat_pkg::MAX_PAGES));
  assign sts_o.too_few    = (pages > (RW+1)'(free_count_q));
  assign sts_o.pages_zero = (pages == '0);
  assign sts_o.len_zero   = (cur_len == '0);
  assign sts_o.page_oob   = (page >= AW'(cur_len));
  assign sts_o.last       = ((LW'(idx_q) + LW'(1)) == cur_len);

  pfat_ram #(.W(FW), .DEPTH(pfat_pkg::MAX_FRAMES)) u_stack (
    .clk_i   (clk_i),
    .we_i    (cmd_i.push_wr && !stack_full),
    .waddr_i (free_count_q[FW-1:0]),
    .wdata_i (tbl_rdata),
    .re_i    (cmd_i.pop_rd),
    .raddr_i (cnt_dec[FW-1:0]),
    .rdata_o (stk_rdata)
  );

  pfat_ram #(.W(FW), .DEPTH(pfat_pkg::TBL_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (cmd_i.pop_wr),
    .waddr_i ({slot_q, idx_q}),
    .wdata_i (pop_frame),
    .re_i    (cmd_i.push_rd || cmd_i.xlate_rd),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      page_bits_q  <= pfat_pkg::PAGE_BITS_RST;
      phys_bits_q  <= pfat_pkg::PHYS_BITS_RST;
      free_count_q <= frame_total(pfat_pkg::PAGE_BITS_RST, pfat_pkg::PHYS_BITS_RST);
      valid_q      <= '0;
      use_q        <= '0;
      idx_q        <= '0;
      done_q       <= 1'b0;
      for (int i = 0; i < pfat_pkg::MAX_SLOTS; i++) len_q[i] <= '0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          pfat_pkg::REG_PAGE_BITS: page_bits_q <= cfg_data_i;
          pfat_pkg::REG_PHYS_BITS: phys_bits_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.latch) idx_q <= '0;
      if (cmd_i.setup) begin
        free_count_q <= frame_total(page_bits_q, phys_bits_q);
        valid_q      <= '0;
        use_q        <= '0;
        for (int i = 0; i < pfat_pkg::MAX_SLOTS; i++) len_q[i] <= '0;
      end
      if (cmd_i.claim) begin
        use_q[slot_q] <= 1'b1;
        len_q[slot_q] <= pages[LW-1:0];
      end
      if (cmd_i.free_slot) begin
        use_q[slot_q] <= 1'b0;
        len_q[slot_q] <= '0;
      end
      if (cmd_i.pop_wr) begin
        free_count_q <= cnt_dec;
        idx_q        <= idx_q + PW'(1);
      end
      if (cmd_i.push_wr) begin
        idx_q <= idx_q + PW'(1);
        if (!stack_full) begin
          free_count_q                  <= free_count_q + CW'(1);
          valid_q[free_count_q[FW-1:0]] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q   <= pfat_pkg::pfat_op_e'(op_i);
      slot_q <= process_slot_i;
      req_q  <= mem_req_i;
      addr_q <= address_i;
    end
    if (cmd_i.stat_set) stat_q <= cmd_i.stat;
    if (cmd_i.pop_rd) begin
      sel_addr_q  <= cnt_dec[FW-1:0];
      sel_valid_q <= valid_q[cnt_dec[FW-1:0]];
    end
    if (cmd_i.emit) begin
      status_q      <= stat_q;
      free_frames_q <= free_count_q;
      frame_q       <= (op_q == pfat_pkg::OP_ACCESS && stat_q == pfat_pkg::STAT_OK)
                       ? tbl_rdata : '0;
      offset_q      <= (op_q == pfat_pkg::OP_ACCESS && stat_q != pfat_pkg::STAT_EMPTY)
                       ? offset : '0;
      if (op_q == pfat_pkg::OP_CREATE &&
          (stat_q == pfat_pkg::STAT_OK || stat_q == pfat_pkg::STAT_FEW)) begin
        pages_q <= pages[pfat_pkg::PAGES_W-1:0];
        frag_q  <= frag;
      end else begin
        pages_q <= '0;
        frag_q  <= '0;
      end
    end
  end

  assign done_o            = done_q;
  assign status_o          = status_q;
  assign frame_o           = frame_q;
  assign offset_o          = offset_q;
  assign pages_allocated_o = pages_q;
  assign fragmentation_o   = frag_q;
  assign free_frames_o     = free_frames_q;

endmodule
`default_nettype wire

[hw/rtl/paged_frame_allocator_translator.sv]
`default_nettype none
// Paged frame allocator and translator with a free-frame stack and eight process slots.
// A request is taken when start_i is high and busy_o is low; its result is shown for one
// cycle with done_o and cannot be held off. Setup, access and refused requests go from
// decode straight to the done state; create and terminate first walk each frame moved
// (up to 64) one at a time, in a read and a write state, through the registered-read
// stack and page-table memories. busy_o is low again in the cycle done_o is high, so the
// next request may be given then. Configuration writes belong between requests, while
// busy_o is low; the page size applies from the next request and the physical size
// reaches the frame count only at the next setup.
module paged_frame_allocator_translator (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [pfat_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [pfat_pkg::CFG_W-1:0]     cfg_data_i,
  input  wire logic                           start_i,
  output logic                                busy_o,
  input  wire logic [pfat_pkg::OP_W-1:0]      op_i,
  input  wire logic [pfat_pkg::SLOT_W-1:0]    process_slot_i,
  input  wire logic [pfat_pkg::REQ_W-1:0]     mem_req_i,
  input  wire logic [pfat_pkg::ADDR_W-1:0]    address_i,
  output logic                                done_o,
  output logic [pfat_pkg::STAT_W-1:0]         status_o,
  output logic [pfat_pkg::FRAME_W-1:0]        frame_o,
  output logic [pfat_pkg::OFF_W-1:0]          offset_o,
  output logic [pfat_pkg::PAGES_W-1:0]        pages_allocated_o,
  output logic [pfat_pkg::OFF_W-1:0]          fragmentation_o,
  output logic [pfat_pkg::CNT_W-1:0]          free_frames_o
);

  pfat_pkg::pfat_cmd_t cmd;
  pfat_pkg::pfat_sts_t sts;

  pfat_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .sts_i   (sts),
    .cmd_o   (cmd),
    .busy_o  (busy_o)
  );

  pfat_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .op_i              (op_i),
    .process_slot_i    (process_slot_i),
    .mem_req_i         (mem_req_i),
    .address_i         (address_i),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .done_o            (done_o),
    .status_o          (status_o),
    .frame_o           (frame_o),
    .offset_o          (offset_o),
    .pages_allocated_o (pages_allocated_o),
    .fragmentation_o   (fragmentation_o),
    .free_frames_o     (free_frames_o)
  );

`ifndef SYNTH
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("result beat while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("accepted request not busy");

  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (free_frames_o <= pfat_pkg::CNT_W'(pfat_pkg::MAX_FRAMES)))
    else $error("free frame count out of range");
`endif

endmodule
`default_nettype wire

[verif/testbench.sv]
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;

  typedef enum logic [1:0] {BEAT_REQ, BEAT_CFG, BEAT_DRAIN} beat_kind_e;

  typedef struct {
    beat_kind_e                          kind;
    pfat_pkg::pfat_op_e                  op;
    logic [pfat_pkg::SLOT_W-1:0]         slot;
    logic [pfat_pkg::REQ_W-1:0]          req;
    logic [pfat_pkg::ADDR_W-1:0]         addr;
    logic [pfat_pkg::CFG_IDX_W-1:0]      cfg_idx;
    logic [pfat_pkg::CFG_W-1:0]          cfg_data;
  } beat_t;

  typedef struct {
    pfat_pkg::pfat_status_e              status;
    logic [pfat_pkg::FRAME_W-1:0]        frame;
    logic [pfat_pkg::OFF_W-1:0]          offset;
    logic [pfat_pkg::PAGES_W-1:0]        pages;
    logic [pfat_pkg::OFF_W-1:0]          frag;
    logic [pfat_pkg::CNT_W-1:0]          free_cnt;
  } xlate_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [pfat_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [pfat_pkg::CFG_W-1:0] cfg_data_i = '0;
  logic start_i = 1'b0;
  logic [pfat_pkg::OP_W-1:0] op_i = '0;
  logic [pfat_pkg::SLOT_W-1:0] process_slot_i = '0;
  logic [pfat_pkg::REQ_W-1:0] mem_req_i = '0;
  logic [pfat_pkg::ADDR_W-1:0] address_i = '0;
  logic busy_o, done_o;
  logic [pfat_pkg::STAT_W-1:0] status_o;
  logic [pfat_pkg::FRAME_W-1:0] frame_o;
  logic [pfat_pkg::OFF_W-1:0] offset_o;
  logic [pfat_pkg::PAGES_W-1:0] pages_allocated_o;
  logic [pfat_pkg::OFF_W-1:0] fragmentation_o;
  logic [pfat_pkg::CNT_W-1:0] free_frames_o;

  paged_frame_allocator_translator DUT (.*);

  always #6 clk_i = ~clk_i;

  beat_t pending_beats[$];
  xlate_result_t expected_results[$];
  int errors = 0;
  int idle_cycles = 0;
  bit just_accepted = 0;
  int gap_left = 0;
  int burst_left = 1;

  // shadow allocator state
  logic [pfat_pkg::CFG_W-1:0]   pg_bits = pfat_pkg::PAGE_BITS_RST;
  logic [pfat_pkg::CFG_W-1:0]   ph_bits = pfat_pkg::PHYS_BITS_RST;
  logic [pfat_pkg::FRAME_W-1:0] free_stack[pfat_pkg::MAX_FRAMES];
  int                           free_cnt;
  logic [pfat_pkg::FRAME_W-1:0] page_table[pfat_pkg::TBL_DEPTH];
  int                           table_len[pfat_pkg::MAX_SLOTS];
  bit                           slot_busy[pfat_pkg::MAX_SLOTS];

  function automatic int frame_count();
    int d;
    if (ph_bits < pg_bits) return 0;
    d = ph_bits - pg_bits;
    if (d >= pfat_pkg::FRAME_W) return pfat_pkg::MAX_FRAMES;
    return 1 << d;
  endfunction

  function automatic void refill_frames();
    for (int i = 0; i < pfat_pkg::MAX_FRAMES; i++) free_stack[i] = pfat_pkg::FRAME_W'(i);
    free_cnt = frame_count();
    for (int s = 0; s < pfat_pkg::MAX_SLOTS; s++) begin
      table_len[s] = 0;
      slot_busy[s] = 0;
    end
  endfunction

  function automatic void translate_request(beat_t b);
    xlate_result_t r;
    longint unsigned pg_size, pages, page;
    int s;
    r = '{pfat_pkg::STAT_OK, '0, '0, '0, '0, '0};
    pg_size = 64'd1 << pg_bits;
    s = b.slot;
    case (b.op)
      pfat_pkg::OP_SETUP: refill_frames();
      pfat_pkg::OP_CREATE: begin
        if (slot_busy[s]) begin
          r.status = pfat_pkg::STAT_BUSY;
        end else begin
          pages = (longint'(b.req) + pg_size - 1) >> pg_bits;
          if (pages > pfat_pkg::MAX_PAGES) begin
            r.status = pfat_pkg::STAT_TOO_MANY;
          end else begin
            r.pages = pfat_pkg::PAGES_W'(pages);
            r.frag = pfat_pkg::OFF_W'((pg_size - (longint'(b.req) & (pg_size - 1)))
                                      & (pg_size - 1));
            if (pages > free_cnt) begin
              r.status = pfat_pkg::STAT_FEW;
            end else begin
              for (int i = 0; i < pages; i++) begin
                free_cnt--;
                page_table[s * pfat_pkg::MAX_PAGES + i] = free_stack[free_cnt];
              end
              table_len[s] = int'(pages);
              slot_busy[s] = 1;
            end
          end
        end
      end
      pfat_pkg::OP_TERMINATE: begin
        if (!slot_busy[s]) begin
          r.status = pfat_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < table_len[s]; i++) begin
            if (free_cnt < pfat_pkg::MAX_FRAMES) begin
              free_stack[free_cnt] = page_table[s * pfat_pkg::MAX_PAGES + i];
              free_cnt++;
            end
          end
          table_len[s] = 0;
          slot_busy[s] = 0;
        end
      end
      default: begin
        if (!slot_busy[s]) begin
          r.status = pfat_pkg::STAT_EMPTY;
        end else begin
          page = longint'(b.addr) >> pg_bits;
          r.offset = pfat_pkg::OFF_W'(longint'(b.addr) & (pg_size - 1));
          if (page >= table_len[s]) r.status = pfat_pkg::STAT_NO_PAGE;
          else r.frame = page_table[s * pfat_pkg::MAX_PAGES + int'(page)];
        end
      end
    endcase
    r.free_cnt = pfat_pkg::CNT_W'(free_cnt);
    expected_results = {expected_results, r};
  endfunction

  function automatic void check_field(string name, longint unsigned exp_v,
                                      longint unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d, actual %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // driver
  always @(negedge clk_i) begin : drive
    bit offer_open, go, we;
    beat_t head;
    go = 0;
    we = 0;
    offer_open = start_i && !just_accepted;
    if (rst_ni && pending_beats.size() > 0) begin
      if (!offer_open && gap_left > 0) begin
        gap_left--;
      end else begin
        head = pending_beats[0];
        case (head.kind)
          BEAT_REQ: begin
            go = 1;
            op_i <= head.op;
            process_slot_i <= head.slot;
            mem_req_i <= head.req;
            address_i <= head.addr;
            if (!offer_open) begin
              burst_left--;
              if (burst_left <= 0) begin
                burst_left = $urandom_range(1, 24);
                gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
              end
            end
          end
          BEAT_CFG: begin
            if (expected_results.size() == 0 && !busy_o) begin
              we = 1;
              cfg_idx_i <= head.cfg_idx;
              cfg_data_i <= head.cfg_data;
              if (head.cfg_idx == pfat_pkg::REG_PAGE_BITS) pg_bits = head.cfg_data;
              else ph_bits = head.cfg_data;
              void'(pending_beats.pop_front());
            end
          end
          default: begin
            if (expected_results.size() == 0) void'(pending_beats.pop_front());
          end
        endcase
      end
    end
    start_i <= go;
    cfg_we_i <= we;
  end

  // monitor
  always @(posedge clk_i) begin : observe
    xlate_result_t e;
    bit progress;
    progress = 0;
    just_accepted = 0;
    if (rst_ni) begin
      if (done_o) begin
        progress = 1;
        if (expected_results.size() == 0) begin
          $display("%0t unexpected result beat: status %0d", $time, status_o);
          errors++;
        end else begin
          e = expected_results.pop_front();
          check_field("status", e.status, status_o);
          check_field("frame", e.frame, frame_o);
          check_field("offset", e.offset, offset_o);
          check_field("pages_allocated", e.pages, pages_allocated_o);
          check_field("fragmentation", e.frag, fragmentation_o);
          check_field("free_frames", e.free_cnt, free_frames_o);
        end
      end
      if (start_i && !busy_o) begin
        translate_request(pending_beats.pop_front());
        just_accepted = 1;
        progress = 1;
      end
      if (cfg_we_i) progress = 1;
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  function automatic void add_req(pfat_pkg::pfat_op_e op, int slot, longint unsigned req,
                                  longint unsigned addr);
    beat_t b;
    b.kind = BEAT_REQ;
    b.op = op;
    b.slot = pfat_pkg::SLOT_W'(slot);
    b.req = pfat_pkg::REQ_W'(req);
    b.addr = pfat_pkg::ADDR_W'(addr);
    b.cfg_idx = '0;
    b.cfg_data = '0;
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void add_cfg(int pb, int phys);
    beat_t b;
    b.kind = BEAT_CFG;
    b.op = pfat_pkg::OP_SETUP;
    b.slot = '0;
    b.req = '0;
    b.addr = '0;
    b.cfg_idx = pfat_pkg::REG_PAGE_BITS;
    b.cfg_data = pfat_pkg::CFG_W'(pb);
    pending_beats = {pending_beats, b};
    b.cfg_idx = pfat_pkg::REG_PHYS_BITS;
    b.cfg_data = pfat_pkg::CFG_W'(phys);
    pending_beats = {pending_beats, b};
  endfunction

  function automatic void add_drain();
    beat_t b;
    b = pending_beats[0];
    b.kind = BEAT_DRAIN;
    pending_beats = {pending_beats, b};
  endfunction

  function automatic longint unsigned pick_bytes(int pb, int pages_hi);
    case ($urandom_range(0, 11))
      0: return 0;
      1: return $urandom_range(0, (1 << pfat_pkg::REQ_W) - 1);
      2: return (longint'($urandom_range(0, pages_hi)) << pb);
      default: return $urandom_range(0, (pages_hi << pb) > ((1 << pfat_pkg::REQ_W) - 1) ?
                                      ((1 << pfat_pkg::REQ_W) - 1) : (pages_hi << pb));
    endcase
  endfunction

  int cfg_pb[12] = '{8, 4, 16, 4, 16, 10, 5, 13, 12, 6, 9, 8};
  int cfg_ph[12] = '{16, 4, 24, 24, 4, 14, 11, 23, 18, 7, 19, 16};

  initial begin
    int pb, sel;
    refill_frames();
    // directed part at reset configuration
    add_req(pfat_pkg::OP_CREATE, 0, 0, 0);
    add_req(pfat_pkg::OP_CREATE, 0, 5, 0);
    add_req(pfat_pkg::OP_ACCESS, 0, 0, 'h3FFFFF);
    add_req(pfat_pkg::OP_TERMINATE, 0, 0, 0);
    add_req(pfat_pkg::OP_TERMINATE, 0, 0, 0);
    add_req(pfat_pkg::OP_ACCESS, 1, 0, 0);
    add_req(pfat_pkg::OP_CREATE, 1, 'h3FFFFF, 0);
    add_req(pfat_pkg::OP_CREATE, 2, 64 * 256, 0);
    add_req(pfat_pkg::OP_CREATE, 3, 64 * 256 - 1, 0);
    add_req(pfat_pkg::OP_CREATE, 4, 63 * 256 + 1, 0);
    add_req(pfat_pkg::OP_CREATE, 5, 64 * 256, 0);
    add_req(pfat_pkg::OP_CREATE, 6, 1, 0);
    add_req(pfat_pkg::OP_ACCESS, 2, 0, 0);
    add_req(pfat_pkg::OP_ACCESS, 2, 0, 64 * 256 - 1);
    add_req(pfat_pkg::OP_ACCESS, 2, 0, 64 * 256);
    add_req(pfat_pkg::OP_ACCESS, 7, 0, 0);
    add_req(pfat_pkg::OP_TERMINATE, 3, 0, 0);
    add_req(pfat_pkg::OP_CREATE, 6, 1, 0);
    add_req(pfat_pkg::OP_ACCESS, 6, 0, 255);
    add_req(pfat_pkg::OP_TERMINATE, 2, 0, 0);
    add_req(pfat_pkg::OP_SETUP, 0, 0, 0);
    add_req(pfat_pkg::OP_ACCESS, 4, 0, 0);
    add_drain();

    for (int ph = 0; ph < 12; ph++) begin
      pb = cfg_pb[ph];
      add_cfg(pb, cfg_ph[ph]);
      add_req(pfat_pkg::OP_SETUP, $urandom_range(0, 7), $urandom, $urandom);
      for (int n = 0; n < 128; n++) begin
        sel = $urandom_range(0, 99);
        if (sel < 3)
          add_req(pfat_pkg::OP_SETUP, $urandom_range(0, 7), $urandom, $urandom);
        else if (sel < 33)
          add_req(pfat_pkg::OP_CREATE, $urandom_range(0, 7), pick_bytes(pb, 16), $urandom);
        else if (sel < 53)
          add_req(pfat_pkg::OP_TERMINATE, $urandom_range(0, 7), $urandom, $urandom);
        else
          add_req(pfat_pkg::OP_ACCESS, $urandom_range(0, 7), $urandom, pick_bytes(pb, 20));
        if (n == 64 && ph % 3 == 0) add_drain();
      end
      add_drain();
    end

    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    while (pending_beats.size() > 0 || expected_results.size() > 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
hw/rtl/pfat_pkg.sv
hw/rtl/pfat_ram.sv
hw/rtl/pfat_ctrl.sv
hw/rtl/pfat_dp.sv
hw/rtl/paged_frame_allocator_translator.sv
verif/testbench.sv
